FILE: rtl/bcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_pkg: shared types and constants
// Status codes, request kinds and the front-to-back command record.
// ----------------------------------------------------------------------------
package bcpa_pkg;

  localparam int MAX_PAGES = 1024;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        range_bad;
    logic [9:0]  start;
    logic [10:0] len;
  } cmd_t;

endpackage

FILE: rtl/bcpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_front: request intake and classification
// Accepts requests, checks free bounds and pushes commands into a queue.
// ----------------------------------------------------------------------------
module bcpa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [9:0]         start_index,
  input  logic [10:0]        run_length,
  input  logic [10:0]        npages,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output bcpa_pkg::cmd_t     cmd
);

  bcpa_pkg::cmd_t q [2];
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           push, pop;
  bcpa_pkg::cmd_t c;

  always_comb begin
    c.kind      = req_type;
    c.start     = start_index;
    c.len       = run_length;
    c.range_bad = ({2'b0, start_index} + {1'b0, run_length}) > {1'b0, npages};
  end

  assign in_ready  = (cnt != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= c;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd2) |-> !in_ready)
    else $error("accept while queue full");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop && cnt == 2'd0) |=> cmd_valid)
    else $error("pushed command lost");

endmodule

FILE: rtl/bcpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_back: bitmap executor
// Runs first-fit search, marking and freeing one page per cycle; clears the
// bitmap in one pass over all pages after reset and after a page count write.
// ----------------------------------------------------------------------------
module bcpa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [10:0]        npages,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  bcpa_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [9:0]         first_page,
  output logic [10:0]        pages_changed,
  output logic [10:0]        free_pages
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MARK = 6'b000100,
    S_FREE = 6'b001000,
    S_DONE = 6'b010000,
    S_CLR  = 6'b100000
  } state_t;

  localparam int PAGES = bcpa_pkg::MAX_PAGES;

  state_t      state;
  logic        busy [PAGES];
  logic [10:0] p, s, run, len, endp, chg, fcnt;
  logic        cur;
  logic [9:0]  raddr;
  logic        mem_we, mem_wd;
  logic        take;

  assign cmd_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take      = cmd_valid && cmd_ready;

  // Address the page p holds next cycle, so cur carries busy[p] in scan and free.
  always_comb begin
    case (state)
      S_IDLE:         raddr = (cmd.kind == bcpa_pkg::REQ_FREE) ? cmd.start : 10'd0;
      S_SCAN, S_FREE: raddr = p[9:0] + 10'd1;
      default:        raddr = p[9:0];
    endcase
  end

  assign mem_we = (state == S_CLR) || ((state == S_MARK || state == S_FREE) && p != endp);
  assign mem_wd = (state == S_MARK);

  always_ff @(posedge clk) begin
    if (mem_we) busy[p[9:0]] <= mem_wd;
    cur <= busy[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_CLR;
      p <= 11'd0;
      out_valid <= 1'b0;
      fcnt <= 11'd0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          if (p == 11'(PAGES - 1)) begin
            fcnt <= npages; state <= S_IDLE;
          end
          p <= p + 11'd1;
        end
        S_IDLE: if (take) begin
          len <= cmd.len; chg <= 11'd0; run <= 11'd0;
          first_page <= 10'd0;
          if (cmd.kind == bcpa_pkg::REQ_FREE) begin
            if (cmd.range_bad) begin
              status <= bcpa_pkg::ST_RANGE; state <= S_DONE;
            end else begin
              status <= bcpa_pkg::ST_OK; p <= {1'b0, cmd.start};
              endp <= {1'b0, cmd.start} + cmd.len; state <= S_FREE;
            end
          end else if (cmd.len > npages) begin
            status <= bcpa_pkg::ST_NOFIT; state <= S_DONE;
          end else begin
            p <= 11'd0; state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (p >= npages) begin
            status <= bcpa_pkg::ST_NOFIT; state <= S_DONE;
          end else if (cur) begin
            run <= 11'd0; p <= p + 11'd1;
          end else if (len == 11'd0) begin
            status <= bcpa_pkg::ST_OK; first_page <= p[9:0]; state <= S_DONE;
          end else begin
            if (run == 11'd0) s <= p;
            if (run + 11'd1 >= len) begin
              status <= bcpa_pkg::ST_OK;
              first_page <= (run == 11'd0) ? p[9:0] : s[9:0];
              p <= (run == 11'd0) ? p : s;
              endp <= p + 11'd1;
              state <= S_MARK;
            end else begin
              run <= run + 11'd1; p <= p + 11'd1;
            end
          end
        end
        S_MARK: begin
          if (p == endp) begin
            chg <= len; fcnt <= fcnt - len; state <= S_DONE;
          end else begin
            p <= p + 11'd1;
          end
        end
        S_FREE: begin
          if (p == endp) begin
            fcnt <= fcnt + chg; state <= S_DONE;
          end else begin
            if (cur) chg <= chg + 11'd1;
            p <= p + 11'd1;
          end
        end
        S_DONE: begin
          pages_changed <= chg; free_pages <= fcnt;
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst) fcnt <= 11'(PAGES))
    else $error("free count above page count");
  assert property (@(posedge clk) disable iff (rst || cfg_we)
    (out_valid && !out_ready) |=> out_valid && $stable(free_pages))
    else $error("stalled result changed");

endmodule

FILE: rtl/bitmap_contiguous_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_contiguous_page_allocator_unit: first-fit contiguous page allocator
// Keeps a busy bitmap and a free count; allocates and frees page runs.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready with req_type, start_index and
// run_length; one result per request leaves on out_valid/out_ready with
// status, first_page, pages_changed and free_pages.
// A front stage classifies requests into a two-entry queue; a back stage
// walks the bitmap one page per cycle. An allocate scans from page 0 up to
// the first free run of run_length pages (for a zero-length allocate, the
// first free page; up to the page count when nothing fits), then marks it;
// a free walks its run, clearing it and counting busy pages; an out-of-range
// free or an allocate longer than the page count goes straight to the result.
// One request runs at a time; the next starts at the edge the result leaves.
// cfg_we/cfg_data write the page count (saturated to MAX_PAGES) and reload
// the free count. After reset and after each write the back stage clears
// the bitmap in one pass over all MAX_PAGES pages; requests queue meanwhile.
// When the receiver stalls, the result holds, the back stage waits and the
// queue takes up to two more requests before in_ready drops.
// ----------------------------------------------------------------------------
module bitmap_contiguous_page_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [9:0]  start_index,
  input  logic [10:0] run_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  first_page,
  output logic [10:0] pages_changed,
  output logic [10:0] free_pages
);

  logic [10:0]    npages, npages_next;
  logic           cmd_valid, cmd_ready;
  bcpa_pkg::cmd_t cmd;

  assign npages_next = (cfg_data > 11'(bcpa_pkg::MAX_PAGES)) ? 11'(bcpa_pkg::MAX_PAGES)
                                                             : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) npages <= 11'(bcpa_pkg::MAX_PAGES);
    else if (cfg_we) npages <= npages_next;
  end

  bcpa_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .start_index, .run_length,
    .npages, .cmd_valid, .cmd_ready, .cmd
  );

  bcpa_back u_back (
    .clk, .rst, .cfg_we, .npages, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .status, .first_page, .pages_changed, .free_pages
  );

endmodule
